@@ sv/nfa_pkg.sv @@
// Shared constants, types and helpers for the next-fit identifier allocator.
package nfa_pkg;

    localparam int ID_BITS        = 8;
    localparam int STORE_CAPACITY = 256;
    localparam int OFF_W          = 4;
    localparam int ROW_W          = ID_BITS - OFF_W;
    localparam int WORD_W         = 2 ** OFF_W;
    localparam int ROWS           = 2 ** ROW_W;
    localparam int CNT_W          = ID_BITS + 1;
    localparam int K_W            = ROW_W + 1;
    localparam int ID_MASK        = (2 ** ID_BITS) - 1;

    // Request codes and status codes as seen on the ports.
    localparam logic ACT_GEN = 1'b0;
    localparam logic ACT_REL = 1'b1;
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FULL = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [ROW_W-1:0]  rd_addr;
        logic              wr_en;
        logic [ROW_W-1:0]  wr_addr;
        logic [WORD_W-1:0] wr_data;
    } t_map_req;

    // Position of the lowest set bit; zero when none is set.
    function automatic logic [OFF_W-1:0] low_set(input logic [WORD_W-1:0] w);
        logic [OFF_W-1:0] pos;
        pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w[b]) begin
                pos = OFF_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

@@ sv/nfa_map.sv @@
// In-use map: word-wide synchronous memory with per-row valid bits.
module nfa_map
    import nfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_map_req          i_req,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_row_vld;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_row_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_row_vld[i_req.rd_addr];
            end
        end
    end

    // A row never written reads as all free.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ sv/next_fit_id_allocator_top.sv @@
// Next-fit identifier allocator: request control, word scan and result register.
// Release: accept, one map read, write back, result.
// Generate: scans 16-bit map words from the id after the last issued id, one
//   word per cycle through the synchronous map read port; when the space is full
//   it answers without a scan. One item at a time; o_stall is high from
//   accept until the result is loaded. Sync active-low reset clears map, last id, count.
module next_fit_id_allocator_top
    import nfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_action,
    input  logic [7:0] i_release_id,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_allocated_id,
    output logic       o_status
);

    t_state             r_state, n_state;
    logic [ID_BITS-1:0] r_last, n_last;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ID_BITS-1:0] r_start, n_start;
    logic [ID_BITS-1:0] r_rel_id, n_rel_id;
    logic [K_W-1:0]     r_k, n_k;
    logic               r_chk_vld, n_chk_vld;
    logic [K_W-1:0]     r_chk_k, n_chk_k;
    logic [ROW_W-1:0]   r_chk_addr, n_chk_addr;
    logic [7:0]         r_res_id, n_res_id;
    logic               r_res_status, n_res_status;
    logic               r_o_valid;
    logic [7:0]         r_o_id;
    logic               r_o_status;

    t_map_req           map_req;
    logic [WORD_W-1:0]  rd_word;
    logic               accept;
    logic               full;
    logic               load_out;
    logic [WORD_W-1:0]  scan_mask;
    logic [WORD_W-1:0]  free_bits;
    logic [OFF_W-1:0]   free_pos;
    logic [ID_BITS-1:0] found_id;
    logic [OFF_W-1:0]   start_off;

    nfa_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (rd_word)
    );

    assign accept    = i_valid && !o_stall;
    assign full      = (r_count > CNT_W'(ID_MASK)) || (r_count >= CNT_W'(STORE_CAPACITY));
    assign load_out  = (r_state == S_DONE) && (!r_o_valid || !i_stall);
    assign start_off = r_start[OFF_W-1:0];

    // First word looks at bits from the start offset up; the wrapped pass over
    // the same word looks only below it; every other word is searched whole.
    always_comb begin
        scan_mask = '1;
        if (r_chk_k == '0) begin
            scan_mask = '1 << start_off;
        end else if (r_chk_k == K_W'(ROWS)) begin
            scan_mask = ~('1 << start_off);
        end
    end

    assign free_bits = ~rd_word & scan_mask;
    assign free_pos  = low_set(free_bits);
    assign found_id  = {r_chk_addr, free_pos};

    always_comb begin
        n_state      = r_state;
        n_last       = r_last;
        n_count      = r_count;
        n_start      = r_start;
        n_rel_id     = r_rel_id;
        n_k          = r_k;
        n_chk_vld    = 1'b0;
        n_chk_k      = r_chk_k;
        n_chk_addr   = r_chk_addr;
        n_res_id     = r_res_id;
        n_res_status = r_res_status;
        map_req      = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_REL) begin
                        // Fetch the word that holds the released bit.
                        n_rel_id        = i_release_id[ID_BITS-1:0];
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = i_release_id[ID_BITS-1:OFF_W];
                        n_state         = S_REL;
                    end else if (full) begin
                        n_res_id     = '0;
                        n_res_status = ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_start = r_last + 1'b1;
                        n_k     = '0;
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // Issue one word read per cycle; check the word read last cycle.
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = r_start[ID_BITS-1:OFF_W] + r_k[ROW_W-1:0];
                n_chk_vld       = 1'b1;
                n_chk_k         = r_k;
                n_chk_addr      = map_req.rd_addr;
                if (r_k != K_W'(ROWS)) begin
                    n_k = r_k + 1'b1;
                end
                if (r_chk_vld && (free_bits != '0)) begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = r_chk_addr;
                    map_req.wr_data = rd_word | (WORD_W'(1) << free_pos);
                    n_last          = found_id;
                    n_count         = r_count + 1'b1;
                    n_res_id        = 8'(found_id);
                    n_res_status    = ST_OK;
                    n_chk_vld       = 1'b0;
                    n_state         = S_DONE;
                end
            end

            S_REL: begin
                // Clear the bit if it is set; a free identifier is left alone.
                if (rd_word[r_rel_id[OFF_W-1:0]]) begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = r_rel_id[ID_BITS-1:OFF_W];
                    map_req.wr_data = rd_word & ~(WORD_W'(1) << r_rel_id[OFF_W-1:0]);
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                end
                n_res_id     = '0;
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end

            S_DONE: begin
                // Hold until the output register can take the result.
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= '0;
            r_count   <= '0;
            r_chk_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_count   <= n_count;
            r_chk_vld <= n_chk_vld;
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_rel_id     <= n_rel_id;
        r_k          <= n_k;
        r_chk_k      <= n_chk_k;
        r_chk_addr   <= n_chk_addr;
        r_res_id     <= n_res_id;
        r_res_status <= n_res_status;
        if (load_out) begin
            r_o_id     <= r_res_id;
            r_o_status <= r_res_status;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_allocated_id = r_o_id;
    assign o_status       = r_o_status;

endmodule
